// ----- rtl/assert_macros.svh -----
// assertion macros for the rtl files, included by the top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define ASSERT_CLKD(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("%m: property violated");
// expression must never be true outside reset
`define ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("%m: forbidden condition seen");
`else
`define ASSERT_CLKD(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, expr)
`endif

`endif

// ----- rtl/scgc_pkg.sv -----
// types and constants of the stereo color gradient cost block
`timescale 1ns / 1ps

package scgc_pkg;

   localparam int MAX_DISP  = 63;
   localparam int MAX_WIDTH = 2048;

   localparam int CH_W    = 8;
   localparam int GRAD_W  = 9;
   localparam int ALPHA_W = 9;
   localparam int COL_W   = 11;
   localparam int DISP_W  = 6;
   localparam int COST_W  = 18;
   localparam int CLR_W   = 10;
   localparam int GDIFF_W = 9;

   // pixel history memory: one entry per past word, ages up to MAX_DISP
   localparam int AGE_W     = $clog2(MAX_DISP + 1);
   localparam int MEM_AW    = AGE_W;
   localparam int MEM_DEPTH = 1 << MEM_AW;

   // command queue between front and back, depth is a power of two
   localparam int Q_DEPTH = 4;
   localparam int Q_AW    = $clog2(Q_DEPTH);
   localparam int QCNT_W  = $clog2(Q_DEPTH + 1);
   localparam logic [QCNT_W-1:0] Q_CNT_MAX = QCNT_W'(Q_DEPTH);

   localparam logic [ALPHA_W-1:0] ALPHA_ONE   = ALPHA_W'(256);
   localparam logic [ALPHA_W-1:0] ALPHA_RESET = ALPHA_W'(230);
   localparam logic [COST_W-1:0]  COST_MAX    = COST_W'(195840);

   localparam logic [COL_W-1:0] COL_LAST = COL_W'(MAX_WIDTH - 1);

   // register indexes of the configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 9;
   localparam logic [CSR_IDX_W-1:0] CSR_ALPHA  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_BORDER = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_DISP   = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_MATCH  = CSR_IDX_W'(3);

   typedef struct packed {
      logic [CH_W-1:0]   red;
      logic [CH_W-1:0]   green;
      logic [CH_W-1:0]   blue;
      logic [GRAD_W-1:0] grad;   // two's complement
   } pix_type;

   typedef struct packed {
      pix_type left;
      pix_type right;
   } pair_type;

   // one classified input word
   typedef struct packed {
      pair_type          pix;
      logic              op_valid;   // paired or single border cost
      logic              op_border;
      logic              op_l_mem;   // left pixel from history
      logic              op_r_mem;   // right pixel from history
      logic [COL_W-1:0]  op_col;
      logic [AGE_W-1:0]  op_age;     // age of the partner in history
      logic [AGE_W-1:0]  fl_cnt;     // border columns flushed at row end
      logic [COL_W-1:0]  fl_col;     // first flushed column
   } cmd_type;

   typedef struct packed {
      logic [QCNT_W-1:0] count;
      logic              full;
      logic              empty;
   } q_sts_type;

   typedef struct packed {
      logic busy;
      logic pop;
   } back_sts_type;

endpackage

// ----- rtl/scgc_front.sv -----
// front end: column tracking and classification of each accepted word
`timescale 1ns / 1ps

module scgc_front import scgc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic              in_ready,
   input  pair_type          in_pix,
   input  logic              in_row_end,
   input  logic [DISP_W-1:0] disparity,
   input  logic              match_right,
   output logic              push,
   output cmd_type           cmd
);

   logic [COL_W-1:0] col_ff, col_in;
   logic [AGE_W-1:0] d_eff;
   logic [COL_W-1:0] d_col;
   logic             has_pair;
   logic             d_zero;

   assign push = in_valid && in_ready;

   always_comb begin
      d_eff    = (int'(disparity) > MAX_DISP) ? AGE_W'(MAX_DISP) : AGE_W'(disparity);
      d_col    = COL_W'(d_eff);
      has_pair = (col_ff >= d_col);
      d_zero   = (d_eff == '0);

      cmd        = '0;
      cmd.pix    = in_pix;
      cmd.op_age = d_eff;
      if (!match_right) begin
         cmd.op_valid  = 1'b1;
         cmd.op_col    = col_ff;
         cmd.op_border = !has_pair;
         cmd.op_r_mem  = has_pair && !d_zero;
      end else begin
         // right view: cost belongs to the column d back
         cmd.op_valid = has_pair;
         cmd.op_col   = col_ff - d_col;
         cmd.op_l_mem = !d_zero;
         if (in_row_end) begin
            if (has_pair) begin
               cmd.fl_cnt = d_eff;
               cmd.fl_col = col_ff - d_col + COL_W'(1);
            end else begin
               // short row: every column so far is a border column
               cmd.fl_cnt = AGE_W'(col_ff + COL_W'(1));
               cmd.fl_col = '0;
            end
         end
      end
   end

   always_comb begin
      col_in = col_ff;
      if (push) begin
         if (in_row_end || col_ff == COL_LAST) begin
            col_in = '0;
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
      end else begin
         col_ff <= col_in;
      end
   end

endmodule

// ----- rtl/scgc_queue.sv -----
// short command queue between front and back
`timescale 1ns / 1ps

module scgc_queue import scgc_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  cmd_type   push_cmd,
   input  logic      pop,
   output cmd_type   head,
   output q_sts_type sts
);

   cmd_type           slot_ff [Q_DEPTH];
   logic [Q_AW-1:0]   wr_ff;
   logic [Q_AW-1:0]   rd_ff;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;

   assign head      = slot_ff[rd_ff];
   assign sts.count = cnt_ff;
   assign sts.full  = (cnt_ff == Q_CNT_MAX);
   assign sts.empty = (cnt_ff == '0);

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= wr_ff + Q_AW'(1);
         end
         if (pop) begin
            rd_ff <= rd_ff + Q_AW'(1);
         end
         cnt_ff <= cnt_in;
      end
   end

endmodule

// ----- rtl/scgc_back.sv -----
// back end: pixel history, flush sequencer and cost pipeline
`timescale 1ns / 1ps

module scgc_back import scgc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            head,
   input  logic               head_empty,
   output logic               pop,
   input  logic [ALPHA_W-1:0] alpha_q8,
   input  logic [CH_W-1:0]    border_value,
   output logic               out_valid,
   input  logic               out_ready,
   output logic [COST_W-1:0]  out_cost,
   output logic [COL_W-1:0]   out_col,
   output logic               out_last,
   output back_sts_type       sts
);

   function automatic logic [CH_W-1:0] ch_diff(input logic [CH_W-1:0] a,
                                               input logic [CH_W-1:0] b);
      return (a > b) ? (a - b) : (b - a);
   endfunction

   function automatic logic [GDIFF_W-1:0] grad_diff(input logic [GRAD_W-1:0] a,
                                                    input logic [GRAD_W-1:0] b);
      logic signed [GRAD_W:0] dif;
      dif = $signed({a[GRAD_W-1], a}) - $signed({b[GRAD_W-1], b});
      return dif[GRAD_W] ? GDIFF_W'(-dif) : GDIFF_W'(dif);
   endfunction

   logic adv;

   // sequencer
   logic              busy_ff, busy_in;
   logic [AGE_W-1:0]  rem_ff, rem_in;
   logic [AGE_W-1:0]  age_ff, age_in;
   logic [COL_W-1:0]  fcol_ff, fcol_in;
   pair_type          hold_ff;
   logic [MEM_AW-1:0] wp_ff;
   pair_type          hist_ff [MEM_DEPTH];

   logic              iss_valid;
   logic              iss_border;
   logic              iss_l_mem;
   logic              iss_r_mem;
   logic [COL_W-1:0]  iss_col;
   logic              iss_last;
   logic [MEM_AW-1:0] rd_addr;
   pair_type          iss_pix;

   // read stage
   logic              r_valid_ff;
   logic              r_border_ff;
   logic              r_l_mem_ff;
   logic              r_r_mem_ff;
   logic [COL_W-1:0]  r_col_ff;
   logic              r_last_ff;
   pair_type          r_pix_ff;
   pair_type          rd_ff;

   // difference stage
   pix_type              lsel;
   pix_type              rsel;
   logic [CLR_W-1:0]     clr_in;
   logic [GDIFF_W-1:0]   grd_in;
   logic [ALPHA_W-1:0]   alpha_in;
   logic                 a_valid_ff;
   logic [CLR_W-1:0]     a_clr_ff;
   logic [GDIFF_W-1:0]   a_grd_ff;
   logic [ALPHA_W-1:0]   a_alpha_ff;
   logic [COL_W-1:0]     a_col_ff;
   logic                 a_last_ff;

   // product stage
   logic [ALPHA_W+CLR_W-1:0]   pa_in;
   logic [ALPHA_W-1:0]         wgrad;
   logic [ALPHA_W+GDIFF_W-1:0] pg_in;
   logic                       m_valid_ff;
   logic [COST_W-1:0]          m_pa_ff;
   logic [COST_W-1:0]          m_pg_ff;
   logic [COL_W-1:0]           m_col_ff;
   logic                       m_last_ff;

   // output register
   logic              o_valid_ff;
   logic [COST_W-1:0] o_cost_ff;
   logic [COL_W-1:0]  o_col_ff;
   logic              o_last_ff;

   assign adv      = !o_valid_ff || out_ready;
   assign pop      = adv && !busy_ff && !head_empty;
   assign sts.busy = busy_ff;
   assign sts.pop  = pop;

   always_comb begin
      iss_valid  = 1'b0;
      iss_border = 1'b0;
      iss_l_mem  = 1'b0;
      iss_r_mem  = 1'b0;
      iss_col    = fcol_ff;
      iss_last   = 1'b0;
      rd_addr    = wp_ff;
      iss_pix    = hold_ff;
      busy_in    = busy_ff;
      rem_in     = rem_ff;
      age_in     = age_ff;
      fcol_in    = fcol_ff;
      if (busy_ff) begin
         // one border column per cycle while the output is not stalled, oldest left pixel first
         iss_valid  = 1'b1;
         iss_border = 1'b1;
         iss_l_mem  = (age_ff != '0);
         iss_last   = (rem_ff == AGE_W'(1));
         rd_addr    = wp_ff - MEM_AW'(1) - MEM_AW'(age_ff);
         rem_in     = rem_ff - AGE_W'(1);
         age_in     = age_ff - AGE_W'(1);
         fcol_in    = fcol_ff + COL_W'(1);
         busy_in    = (rem_ff != AGE_W'(1));
      end else if (pop) begin
         iss_pix = head.pix;
         if (head.op_valid) begin
            iss_valid  = 1'b1;
            iss_border = head.op_border;
            iss_l_mem  = head.op_l_mem;
            iss_r_mem  = head.op_r_mem;
            iss_col    = head.op_col;
            iss_last   = (head.fl_cnt == '0);
            rd_addr    = wp_ff - MEM_AW'(head.op_age);
            rem_in     = head.fl_cnt;
            age_in     = head.fl_cnt - AGE_W'(1);
            fcol_in    = head.fl_col;
            busy_in    = (head.fl_cnt != '0);
         end else if (head.fl_cnt != '0) begin
            iss_valid  = 1'b1;
            iss_border = 1'b1;
            iss_l_mem  = (head.fl_cnt != AGE_W'(1));
            iss_col    = head.fl_col;
            iss_last   = (head.fl_cnt == AGE_W'(1));
            rd_addr    = wp_ff - MEM_AW'(head.fl_cnt - AGE_W'(1));
            rem_in     = head.fl_cnt - AGE_W'(1);
            age_in     = head.fl_cnt - AGE_W'(2);
            fcol_in    = head.fl_col + COL_W'(1);
            busy_in    = (head.fl_cnt > AGE_W'(1));
         end
      end
   end

   // history memory: age zero never comes from here, so no write bypass
   always_ff @(posedge clock) begin
      if (pop) begin
         hist_ff[wp_ff] <= head.pix;
      end
      if (adv) begin
         rd_ff <= hist_ff[rd_addr];
      end
   end

   always_comb begin
      lsel = r_l_mem_ff ? rd_ff.left : r_pix_ff.left;
      rsel = r_r_mem_ff ? rd_ff.right : r_pix_ff.right;
      if (r_border_ff) begin
         rsel.red   = border_value;
         rsel.green = border_value;
         rsel.blue  = border_value;
         rsel.grad  = {1'b0, border_value};
      end
      clr_in = CLR_W'(ch_diff(lsel.red, rsel.red))
             + CLR_W'(ch_diff(lsel.green, rsel.green))
             + CLR_W'(ch_diff(lsel.blue, rsel.blue));
      grd_in   = grad_diff(lsel.grad, rsel.grad);
      alpha_in = (alpha_q8 > ALPHA_ONE) ? ALPHA_ONE : alpha_q8;
   end

   assign pa_in = a_alpha_ff * a_clr_ff;
   assign wgrad = ALPHA_ONE - a_alpha_ff;
   assign pg_in = wgrad * a_grd_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         if (pop) begin
            hold_ff <= head.pix;
         end
         rem_ff  <= rem_in;
         age_ff  <= age_in;
         fcol_ff <= fcol_in;

         r_border_ff <= iss_border;
         r_l_mem_ff  <= iss_l_mem;
         r_r_mem_ff  <= iss_r_mem;
         r_col_ff    <= iss_col;
         r_last_ff   <= iss_last;
         r_pix_ff    <= iss_pix;

         a_clr_ff   <= clr_in;
         a_grd_ff   <= grd_in;
         a_alpha_ff <= alpha_in;
         a_col_ff   <= r_col_ff;
         a_last_ff  <= r_last_ff;

         m_pa_ff   <= COST_W'(pa_in);
         m_pg_ff   <= COST_W'(pg_in);
         m_col_ff  <= a_col_ff;
         m_last_ff <= a_last_ff;

         o_cost_ff <= m_pa_ff + m_pg_ff;
         o_col_ff  <= m_col_ff;
         o_last_ff <= m_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b0;
         wp_ff      <= '0;
         r_valid_ff <= 1'b0;
         a_valid_ff <= 1'b0;
         m_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else if (adv) begin
         busy_ff    <= busy_in;
         if (pop) begin
            wp_ff <= wp_ff + MEM_AW'(1);
         end
         r_valid_ff <= iss_valid;
         a_valid_ff <= r_valid_ff;
         m_valid_ff <= a_valid_ff;
         o_valid_ff <= m_valid_ff;
      end
   end

   assign out_valid = o_valid_ff;
   assign out_cost  = o_cost_ff;
   assign out_col   = o_col_ff;
   assign out_last  = o_last_ff;

endmodule

// ----- rtl/stereo_color_gradient_cost.sv -----
// top level of the stereo color gradient matching cost slice
//
//  channel  direction  handshake              payload
//  req      in         req_tvalid/req_tready  req_tdata pixel pair, req_tlast row end
//  rsp      out        rsp_tvalid/rsp_tready  rsp_tdata cost and column, rsp_tlast run last
//  csr      in         csr_wr_en              csr_index, csr_wr_data
//
// one word per cycle in the left view while rsp is not stalled; in the right view a row end word
// yields up to 1 + disparity costs in the back end (column + 1 on a row shorter than the disparity),
// issuing one cost per cycle from its flush sequencer when rsp is not stalled, while the four entry
// command queue absorbs following words
// first cost path: command queue, read, difference and product stages, output register
// reset is synchronous and clears control state; the pixel history needs no clearing
// a stalled rsp side stalls the whole cost pipeline; req keeps flowing until the queue fills
`timescale 1ns / 1ps
`include "assert_macros.svh"

module stereo_color_gradient_cost import scgc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // left_red, left_green, left_blue, left_grad, right_red, right_green,
   // right_blue, right_grad, zero pad
   input  logic [71:0]           req_tdata,
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // cost, column, zero pad
   output logic [31:0]           rsp_tdata,
   output logic                  rsp_tlast,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data
);

   logic [ALPHA_W-1:0] alpha_ff;
   logic [CH_W-1:0]    border_ff;
   logic [DISP_W-1:0]  disp_ff;
   logic               match_ff;

   pair_type     in_pix;
   logic         push;
   cmd_type      push_cmd;
   cmd_type      head;
   logic         pop;
   q_sts_type    q_sts;
   back_sts_type b_sts;
   logic [COST_W-1:0] out_cost;
   logic [COL_W-1:0]  out_col;

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff  <= ALPHA_RESET;
         border_ff <= '0;
         disp_ff   <= '0;
         match_ff  <= 1'b0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_ALPHA:  alpha_ff  <= csr_wr_data[ALPHA_W-1:0];
            CSR_BORDER: border_ff <= csr_wr_data[CH_W-1:0];
            CSR_DISP:   disp_ff   <= csr_wr_data[DISP_W-1:0];
            CSR_MATCH:  match_ff  <= csr_wr_data[0];
         endcase
      end
   end

   assign in_pix.left.red    = req_tdata[7:0];
   assign in_pix.left.green  = req_tdata[15:8];
   assign in_pix.left.blue   = req_tdata[23:16];
   assign in_pix.left.grad   = req_tdata[32:24];
   assign in_pix.right.red   = req_tdata[40:33];
   assign in_pix.right.green = req_tdata[48:41];
   assign in_pix.right.blue  = req_tdata[56:49];
   assign in_pix.right.grad  = req_tdata[65:57];

   assign req_tready = !q_sts.full;

   scgc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .in_pix      (in_pix),
      .in_row_end  (req_tlast),
      .disparity   (disp_ff),
      .match_right (match_ff),
      .push        (push),
      .cmd         (push_cmd)
   );

   scgc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head     (head),
      .sts      (q_sts)
   );

   scgc_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head         (head),
      .head_empty   (q_sts.empty),
      .pop          (pop),
      .alpha_q8     (alpha_ff),
      .border_value (border_ff),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .out_cost     (out_cost),
      .out_col      (out_col),
      .out_last     (rsp_tlast),
      .sts          (b_sts)
   );

   assign rsp_tdata = {3'b000, out_col, out_cost};

   // weighted sum stays inside the exact q8 range
   `ASSERT_CLKD(a_cost_range, clock, reset, rsp_tvalid |-> (out_cost <= COST_MAX))
   // the flush sequencer owns the back end until its last border column
   `ASSERT_NEVER(a_pop_while_busy, clock, reset, b_sts.busy && b_sts.pop)
   // queue count never runs past its depth
   `ASSERT_CLKD(a_queue_bound, clock, reset, q_sts.count <= Q_CNT_MAX)

endmodule
